@@ rtl/bsa_pkg.sv @@
package bsa_pkg;

    localparam int MAX_SLOTS_DEFAULT = 256;

    // bitmap word geometry
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;
    localparam logic [WORD_BITS-1:0] ALL_USED = 32'hFFFF_FFFF;

    // field widths
    localparam int BASE_W   = 32;
    localparam int SIZE_W   = 16;
    localparam int COUNT_W  = 9;
    localparam int OPCODE_W = 2;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 8;
    localparam int TOTAL_W  = SIZE_W + COUNT_W;

    // stream and configuration port widths
    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [TOTAL_W-1:0] total_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EXHAUSTED = 3'd1,
        ST_RANGE     = 3'd2,
        ST_MISALIGN  = 3'd3,
        ST_DOUBLE    = 3'd4,
        ST_INVALID   = 3'd5
    } status_t;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_POOL_BASE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OBJECT_SIZE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOT_COUNT  = 2'd2;

    localparam logic [BASE_W-1:0]  POOL_BASE_RST   = 32'd0;
    localparam logic [SIZE_W-1:0]  OBJECT_SIZE_RST = 16'd4;
    localparam logic [COUNT_W-1:0] SLOT_COUNT_RST  = 9'd256;

endpackage

@@ rtl/bsa_ram.sv @@
module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/bitmap_slot_allocator_core.sv @@
// Channel   Beat fields (low bit up)                          Direction
// s_*       tuser: opcode[1:0]; tdata: address[31:0]          in
// m_*       tuser: status[2:0]; tdata: result_address[31:0],  out
//           slot_index[39:32]
// cfg_*     cfg_addr selects pool_base/object_size/slot_count in
//
// One item is in work at a time. Allocate reads and scans the bitmap RAM a word
// at a time until a word with a free bit, then marks it and sums the address.
// Free checks the range, runs the 25-step restoring divider, then, if aligned,
// tests the bit. Reset-all, unused opcode and invalid config go straight to emit.
// rst_n frees every slot at once through per-word valid bits; no clear pass.
// A finished result waits in the output register while the next beat is taken.
module bitmap_slot_allocator_core #(
    parameter int MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bsa_pkg::S_TDATA_W-1:0]   s_tdata,   // address[31:0]
    input  logic [bsa_pkg::S_TUSER_W-1:0]   s_tuser,   // opcode[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bsa_pkg::M_TDATA_W-1:0]   m_tdata,   // result_address[31:0], slot_index[39:32]
    output logic [bsa_pkg::M_TUSER_W-1:0]   m_tuser,   // status[2:0]
    input  logic                            cfg_we,
    input  logic [bsa_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [bsa_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int WORDS  = (MAX_SLOTS + bsa_pkg::WORD_BITS - 1) / bsa_pkg::WORD_BITS;
    localparam int WAW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int IDX_W  = WAW + bsa_pkg::BIT_W;
    localparam int PROD_W = IDX_W + bsa_pkg::SIZE_W;
    localparam int STEP_W = $clog2(bsa_pkg::TOTAL_W);
    localparam int TW     = bsa_pkg::TOTAL_W;
    localparam int SW     = bsa_pkg::SIZE_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AL_READ,
        S_AL_SCAN,
        S_AL_MARK,
        S_AL_SUM,
        S_FR_MUL,
        S_FR_RANGE,
        S_FR_DIV,
        S_FR_READ,
        S_FR_TEST,
        S_EMIT
    } state_t;

    state_t state_reg;

    logic [bsa_pkg::BASE_W-1:0]  pool_base_reg;
    logic [bsa_pkg::SIZE_W-1:0]  object_size_reg;
    logic [bsa_pkg::COUNT_W-1:0] slot_count_reg;

    logic [bsa_pkg::ADDR_W-1:0]    address_reg;
    logic [WAW-1:0]                word_addr_reg;
    logic [bsa_pkg::WORD_BITS-1:0] word_reg;
    logic [bsa_pkg::BIT_W-1:0]     bit_reg;
    logic [PROD_W-1:0]             product_reg;
    logic [TW-1:0]                 total_reg;
    logic [TW-1:0]                 dividend_reg;
    logic [SW-1:0]                 rem_reg;
    logic [TW-1:0]                 quo_reg;
    logic [STEP_W-1:0]             step_reg;
    logic [WORDS-1:0]              word_valid_reg;
    logic                          rd_valid_reg;

    bsa_pkg::status_t           res_status_reg;
    logic [bsa_pkg::ADDR_W-1:0] res_addr_reg;
    logic [bsa_pkg::INDEX_W-1:0] res_index_reg;

    logic                        m_tvalid_reg;
    bsa_pkg::status_t            m_status_reg;
    logic [bsa_pkg::ADDR_W-1:0]  m_addr_reg;
    logic [bsa_pkg::INDEX_W-1:0] m_index_reg;

    logic                          ram_we;
    logic [WAW-1:0]                ram_waddr;
    logic [bsa_pkg::WORD_BITS-1:0] ram_wdata;
    logic                          ram_re;
    logic [WAW-1:0]                ram_raddr;
    logic [bsa_pkg::WORD_BITS-1:0] ram_rdata;

    logic                          config_ok;
    logic [bsa_pkg::WORD_BITS-1:0] word_data;
    logic [bsa_pkg::BIT_W-1:0]     free_bit;
    logic [IDX_W-1:0]              alloc_idx;
    logic [WAW-1:0]                quo_word;
    logic [bsa_pkg::BIT_W-1:0]     quo_bit;
    logic [bsa_pkg::ADDR_W:0]      end_sum;
    logic [SW:0]                   partial;
    logic                          div_take;
    logic                          out_free;
    logic                          in_beat;
    bsa_pkg::opcode_t              in_opcode;

    assign config_ok = (object_size_reg != '0) && (slot_count_reg != '0) &&
                       (32'(slot_count_reg) <= 32'(MAX_SLOTS));

    // a word never written since reset or reset-all reads as all free
    assign word_data = rd_valid_reg ? ram_rdata : '0;

    always_comb
    begin
        free_bit = '0;
        for (int i = bsa_pkg::WORD_BITS - 1; i >= 0; i--)
        begin
            if (!word_data[i])
            begin
                free_bit = bsa_pkg::BIT_W'(i);
            end
        end
    end

    assign alloc_idx = {word_addr_reg, bit_reg};
    assign quo_word  = quo_reg[IDX_W-1:bsa_pkg::BIT_W];
    assign quo_bit   = quo_reg[bsa_pkg::BIT_W-1:0];
    assign end_sum   = {1'b0, pool_base_reg} + (bsa_pkg::ADDR_W + 1)'(total_reg);
    assign partial   = {rem_reg, dividend_reg[TW-1]};
    assign div_take  = partial >= {1'b0, object_size_reg};
    assign out_free  = !m_tvalid_reg || m_tready;
    assign in_beat   = s_tvalid && s_tready;
    assign in_opcode = bsa_pkg::opcode_t'(s_tuser);

    always_comb
    begin
        ram_re    = (state_reg == S_AL_READ) || ((state_reg == S_FR_READ) && (rem_reg == '0));
        ram_raddr = (state_reg == S_FR_READ) ? quo_word : word_addr_reg;
        ram_we    = 1'b0;
        ram_waddr = word_addr_reg;
        ram_wdata = '0;
        if ((state_reg == S_AL_MARK) && (32'(alloc_idx) < 32'(slot_count_reg)))
        begin
            ram_we    = 1'b1;
            ram_wdata = word_reg | (bsa_pkg::WORD_BITS'(1) << bit_reg);
        end
        else if ((state_reg == S_FR_TEST) && word_data[bit_reg])
        begin
            ram_we    = 1'b1;
            ram_wdata = word_data & ~(bsa_pkg::WORD_BITS'(1) << bit_reg);
        end
    end

    bsa_ram #(
        .WIDTH (bsa_pkg::WORD_BITS),
        .DEPTH (WORDS)
    ) u_bitmap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg   <= bsa_pkg::POOL_BASE_RST;
            object_size_reg <= bsa_pkg::OBJECT_SIZE_RST;
            slot_count_reg  <= bsa_pkg::SLOT_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                bsa_pkg::CFG_POOL_BASE:   pool_base_reg   <= cfg_wdata[bsa_pkg::BASE_W-1:0];
                bsa_pkg::CFG_OBJECT_SIZE: object_size_reg <= cfg_wdata[bsa_pkg::SIZE_W-1:0];
                bsa_pkg::CFG_SLOT_COUNT:  slot_count_reg  <= cfg_wdata[bsa_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            word_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (ram_re)
            begin
                rd_valid_reg <= word_valid_reg[ram_raddr];
            end
            if (ram_we)
            begin
                word_valid_reg[ram_waddr] <= 1'b1;
            end
            // drop the beat once taken, unless a new one is loaded right now
            if (m_tvalid_reg && m_tready && (state_reg != S_EMIT))
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        address_reg    <= s_tdata;
                        word_addr_reg  <= '0;
                        res_addr_reg   <= '0;
                        res_index_reg  <= '0;
                        if (in_opcode == bsa_pkg::OP_NONE)
                        begin
                            res_status_reg <= bsa_pkg::ST_OK;
                            state_reg      <= S_EMIT;
                        end
                        else if (!config_ok)
                        begin
                            res_status_reg <= bsa_pkg::ST_INVALID;
                            state_reg      <= S_EMIT;
                        end
                        else
                        begin
                            res_status_reg <= bsa_pkg::ST_OK;
                            case (in_opcode)
                                bsa_pkg::OP_ALLOC: state_reg <= S_AL_READ;
                                bsa_pkg::OP_FREE:  state_reg <= S_FR_MUL;
                                default:
                                begin
                                    word_valid_reg <= '0;
                                    state_reg      <= S_EMIT;
                                end
                            endcase
                        end
                    end
                end

                S_AL_READ:
                begin
                    state_reg <= S_AL_SCAN;
                end

                S_AL_SCAN:
                begin
                    if (word_data == bsa_pkg::ALL_USED)
                    begin
                        if (32'(word_addr_reg) == 32'(WORDS - 1))
                        begin
                            res_status_reg <= bsa_pkg::ST_EXHAUSTED;
                            state_reg      <= S_EMIT;
                        end
                        else
                        begin
                            word_addr_reg <= word_addr_reg + 1'b1;
                            state_reg     <= S_AL_READ;
                        end
                    end
                    else
                    begin
                        word_reg  <= word_data;
                        bit_reg   <= free_bit;
                        state_reg <= S_AL_MARK;
                    end
                end

                S_AL_MARK:
                begin
                    // lowest free bit past the slot count means the pool is full
                    if (32'(alloc_idx) >= 32'(slot_count_reg))
                    begin
                        res_status_reg <= bsa_pkg::ST_EXHAUSTED;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        product_reg   <= PROD_W'(alloc_idx) * PROD_W'(object_size_reg);
                        res_index_reg <= bsa_pkg::index_t'(alloc_idx);
                        state_reg     <= S_AL_SUM;
                    end
                end

                S_AL_SUM:
                begin
                    res_addr_reg <= pool_base_reg + bsa_pkg::addr_t'(product_reg);
                    state_reg    <= S_EMIT;
                end

                S_FR_MUL:
                begin
                    total_reg <= bsa_pkg::total_t'(object_size_reg) *
                                 bsa_pkg::total_t'(slot_count_reg);
                    state_reg <= S_FR_RANGE;
                end

                S_FR_RANGE:
                begin
                    if (end_sum[bsa_pkg::ADDR_W])
                    begin
                        res_status_reg <= bsa_pkg::ST_INVALID;
                        state_reg      <= S_EMIT;
                    end
                    else if ((address_reg < pool_base_reg) || ({1'b0, address_reg} >= end_sum))
                    begin
                        res_status_reg <= bsa_pkg::ST_RANGE;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        dividend_reg <= bsa_pkg::total_t'(address_reg - pool_base_reg);
                        rem_reg      <= '0;
                        quo_reg      <= '0;
                        step_reg     <= '0;
                        state_reg    <= S_FR_DIV;
                    end
                end

                S_FR_DIV:
                begin
                    // one restoring step per cycle, dividend MSB first
                    rem_reg      <= div_take ? SW'(partial - {1'b0, object_size_reg})
                                             : partial[SW-1:0];
                    quo_reg      <= {quo_reg[TW-2:0], div_take};
                    dividend_reg <= {dividend_reg[TW-2:0], 1'b0};
                    step_reg     <= step_reg + 1'b1;
                    if (32'(step_reg) == 32'(TW - 1))
                    begin
                        state_reg <= S_FR_READ;
                    end
                end

                S_FR_READ:
                begin
                    if (rem_reg != '0)
                    begin
                        res_status_reg <= bsa_pkg::ST_MISALIGN;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        word_addr_reg <= quo_word;
                        bit_reg       <= quo_bit;
                        state_reg     <= S_FR_TEST;
                    end
                end

                S_FR_TEST:
                begin
                    if (!word_data[bit_reg])
                    begin
                        res_status_reg <= bsa_pkg::ST_DOUBLE;
                    end
                    else
                    begin
                        res_index_reg <= bsa_pkg::index_t'(quo_reg);
                    end
                    state_reg <= S_EMIT;
                end

                S_EMIT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_addr_reg   <= res_addr_reg;
                        m_index_reg  <= res_index_reg;
                        state_reg    <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_index_reg, m_addr_reg};
    assign m_tuser  = m_status_reg;

endmodule

@@ rtl/bsa_checker.sv @@
module bsa_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bsa_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [bsa_pkg::M_TUSER_W-1:0] m_tuser
);

    logic [1:0] pending_reg;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // count beats taken but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_beat && !out_beat)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (out_beat && !in_beat)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != bsa_pkg::ST_OK) |-> (m_tdata == '0))
        else $error("error result carries nonzero address or index");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_tready)
        else $error("input taken again before the item finished");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (pending_reg != 2'd0))
        else $error("result beat without an outstanding request");

endmodule

bind bitmap_slot_allocator_core bsa_checker u_bsa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ tb/sv/tb_bitmap_slot_allocator_core.sv @@
module tb_bitmap_slot_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bsa_pkg::*;

    localparam int SLOTS       = MAX_SLOTS_DEFAULT;
    localparam int ITEM_TARGET = 1950;
    localparam int SETTLE_CYC  = 40;

    typedef struct packed {
        status_t st;
        addr_t   addr;
        index_t  idx;
    } slot_result_t;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_ADDR_W-1:0] reg_sel;
        logic [CFG_DATA_W-1:0] value;
        opcode_t               op;
        addr_t                 a;
        bit                    typed;
        slot_result_t          want;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // allocator image
    logic [BASE_W-1:0]  cfg_base;
    logic [SIZE_W-1:0]  cfg_size;
    logic [COUNT_W-1:0] cfg_count;
    logic [SLOTS-1:0]   used_map;

    slot_result_t result_q[$];
    dir_row_t     dir_rows[$];
    int           mismatches  = 0;
    int           items_sent  = 0;
    int           burst_left  = 0;
    bit           tx_gapless  = 1'b0;
    int           rx_hold     = 0;
    int           rx_cycle    = 0;

    bitmap_slot_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic slot_result_t predict_slot(input opcode_t op, input addr_t a);
        slot_result_t    r;
        longint unsigned region_end;
        longint unsigned off;
        int unsigned     slot;
        bit              found;
        r.st   = ST_OK;
        r.addr = '0;
        r.idx  = '0;
        if (op == OP_NONE)
            return r;
        if (cfg_size == 0 || cfg_count == 0 || cfg_count > SLOTS)
        begin
            r.st = ST_INVALID;
            return r;
        end
        if (op == OP_CLEAR)
        begin
            used_map = '0;
            return r;
        end
        if (op == OP_ALLOC)
        begin
            r.st  = ST_EXHAUSTED;
            found = 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!found && i < cfg_count && !used_map[i])
                begin
                    found       = 1'b1;
                    used_map[i] = 1'b1;
                    r.st        = ST_OK;
                    r.addr      = cfg_base + addr_t'(i) * addr_t'(cfg_size);
                    r.idx       = index_t'(i);
                end
            end
            return r;
        end
        region_end = 64'(cfg_base) + 64'(cfg_size) * 64'(cfg_count);
        if (region_end > 64'hFFFF_FFFF)
            r.st = ST_INVALID;
        else if (a < cfg_base || 64'(a) >= region_end)
            r.st = ST_RANGE;
        else
        begin
            off = 64'(a - cfg_base);
            if (off % cfg_size != 0)
                r.st = ST_MISALIGN;
            else
            begin
                slot = 32'(off / cfg_size);
                if (slot >= cfg_count)
                    r.st = ST_RANGE;
                else if (!used_map[slot])
                    r.st = ST_DOUBLE;
                else
                begin
                    used_map[slot] = 1'b0;
                    r.idx          = index_t'(slot);
                end
            end
        end
        return r;
    endfunction

    task automatic row_cfg(input logic [CFG_ADDR_W-1:0] sel, input logic [CFG_DATA_W-1:0] value);
        dir_row_t row;
        row.is_cfg  = 1'b1;
        row.reg_sel = sel;
        row.value   = value;
        row.op      = OP_NONE;
        row.a       = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        dir_rows.push_back(row);
    endtask

    task automatic row_item(input opcode_t op, input addr_t a, input bit typed,
                            input status_t st, input addr_t raddr, input index_t idx);
        dir_row_t row;
        row.is_cfg    = 1'b0;
        row.reg_sel   = CFG_POOL_BASE;
        row.value     = '0;
        row.op        = op;
        row.a         = a;
        row.typed     = typed;
        row.want.st   = st;
        row.want.addr = raddr;
        row.want.idx  = idx;
        dir_rows.push_back(row);
    endtask

    // drop valid, drain every outstanding answer, then let the core go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] sel, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= sel;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (sel)
            CFG_POOL_BASE:   cfg_base  = value[BASE_W-1:0];
            CFG_OBJECT_SIZE: cfg_size  = value[SIZE_W-1:0];
            CFG_SLOT_COUNT:  cfg_count = value[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    // returns right at the accepting edge, valid still high; the caller
    // follows up in the same step with another beat or with settle()
    task automatic send_item(input opcode_t op, input addr_t a, input bit typed,
                             input slot_result_t typed_want);
        int           gap;
        slot_result_t want;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (!tx_gapless)
                gap = $urandom_range(0, 25);
        end
        burst_left--;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= a;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = predict_slot(op, a);
        if (typed)
            want = typed_want;
        result_q.push_back(want);
        items_sent++;
    endtask

    always @(posedge clk)
    begin : rx_side
        slot_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: status %0d address %h index %0d",
                                 m_tuser, m_tdata[31:0], m_tdata[39:32]);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (m_tuser != want.st || m_tdata[31:0] != want.addr ||
                        m_tdata[39:32] != want.idx)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: status %0d/%0d address %h/%h index %0d/%0d",
                                     want.st, m_tuser, want.addr, m_tdata[31:0],
                                     want.idx, m_tdata[39:32]);
                    end
                end
            end
            rx_cycle++;
            // steady stretch first, then stalls of random length
            if (rx_cycle % 600 < 150)
                m_tready <= 1'b1;
            else if (rx_hold != 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 3) != 0)
                m_tready <= 1'b1;
            else
            begin
                m_tready <= 1'b0;
                rx_hold = $urandom_range(0, 24);
            end
        end
    end

    initial
    begin : stimulus
        opcode_t         op;
        addr_t           a;
        slot_result_t    none;
        logic [31:0]     new_base;
        logic [31:0]     new_size;
        logic [31:0]     new_count;
        longint unsigned span;
        int              phase_len;
        int              alloc_pct;
        int              r;
        int              start;
        int              pick;
        int              j;

        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        rst_n     <= 1'b0;
        none      = '0;
        cfg_base  = POOL_BASE_RST;
        cfg_size  = OBJECT_SIZE_RST;
        cfg_count = SLOT_COUNT_RST;
        used_map  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: base 0, 4 bytes, 256 slots
        row_item(OP_ALLOC, 32'h0,         1, ST_OK,       32'h0, 8'd0);
        row_item(OP_ALLOC, 32'hFFFF_FFFF, 1, ST_OK,       32'h4, 8'd1);
        row_item(OP_FREE,  32'h0,         1, ST_OK,       32'h0, 8'd0);
        row_item(OP_FREE,  32'h0,         1, ST_DOUBLE,   32'h0, 8'd0);
        row_item(OP_FREE,  32'h2,         1, ST_MISALIGN, 32'h0, 8'd0);
        row_item(OP_FREE,  32'd1024,      1, ST_RANGE,    32'h0, 8'd0);
        row_item(OP_NONE,  32'hFFFF_FFFF, 1, ST_OK,       32'h0, 8'd0);
        row_item(OP_CLEAR, 32'h0,         1, ST_OK,       32'h0, 8'd0);
        row_item(OP_FREE,  32'h4,         1, ST_DOUBLE,   32'h0, 8'd0);
        // allocation addresses wrap; the pool end overflows for free
        row_cfg(CFG_POOL_BASE,   32'hFFFF_FFF0);
        row_cfg(CFG_OBJECT_SIZE, 32'h0000_FFFF);
        row_item(OP_ALLOC, 32'h0,         0, ST_OK,       32'h0, 8'd0);
        row_item(OP_ALLOC, 32'h0,         0, ST_OK,       32'h0, 8'd0);
        row_item(OP_FREE,  32'hFFFF_FFF0, 1, ST_INVALID,  32'h0, 8'd0);
        // invalid object size and slot counts
        row_cfg(CFG_OBJECT_SIZE, 32'h0);
        row_item(OP_ALLOC, 32'h0,         1, ST_INVALID,  32'h0, 8'd0);
        row_item(OP_NONE,  32'h0,         1, ST_OK,       32'h0, 8'd0);
        row_item(OP_CLEAR, 32'h0,         1, ST_INVALID,  32'h0, 8'd0);
        row_cfg(CFG_OBJECT_SIZE, 32'h1);
        row_cfg(CFG_POOL_BASE,   32'h0);
        row_cfg(CFG_SLOT_COUNT,  32'h0);
        row_item(OP_FREE,  32'h0,         1, ST_INVALID,  32'h0, 8'd0);
        row_cfg(CFG_SLOT_COUNT,  32'd511);
        row_item(OP_ALLOC, 32'h0,         1, ST_INVALID,  32'h0, 8'd0);
        // single slot, left used by the wrap rows above
        row_cfg(CFG_SLOT_COUNT,  32'd1);
        row_item(OP_ALLOC, 32'h0,         0, ST_OK,       32'h0, 8'd0);
        row_item(OP_FREE,  32'h0,         0, ST_OK,       32'h0, 8'd0);
        row_item(OP_ALLOC, 32'h0,         0, ST_OK,       32'h0, 8'd0);
        row_item(OP_ALLOC, 32'h0,         0, ST_OK,       32'h0, 8'd0);
        row_item(OP_FREE,  32'h1,         0, ST_OK,       32'h0, 8'd0);
        // stale bit of slot 1 comes back into reach
        row_cfg(CFG_SLOT_COUNT,  32'd256);
        row_item(OP_FREE,  32'h1,         0, ST_OK,       32'h0, 8'd0);
        row_item(OP_FREE,  32'hFFFF_FFFF, 0, ST_OK,       32'h0, 8'd0);
        row_item(OP_CLEAR, 32'h0,         0, ST_OK,       32'h0, 8'd0);

        foreach (dir_rows[n])
        begin
            if (dir_rows[n].is_cfg)
            begin
                settle();
                write_reg(dir_rows[n].reg_sel, dir_rows[n].value);
            end
            else
                send_item(dir_rows[n].op, dir_rows[n].a, dir_rows[n].typed, dir_rows[n].want);
        end

        while (items_sent < ITEM_TARGET)
        begin
            settle();
            case ($urandom_range(0, 5))
                0:       new_base = 32'h0;
                1:       new_base = 32'hFFFF_FFFF;
                2:       new_base = $urandom;
                default: new_base = $urandom_range(0, 32'h00FF_FFFF);
            endcase
            case ($urandom_range(0, 5))
                0:       new_size = 32'd1;
                1:       new_size = 32'd65535;
                2:       new_size = 32'd1 << $urandom_range(0, 15);
                default: new_size = $urandom_range(1, 64);
            endcase
            case ($urandom_range(0, 5))
                0:       new_count = 32'd1;
                1:       new_count = 32'd256;
                2:       new_count = $urandom_range(1, 8);
                default: new_count = $urandom_range(1, 256);
            endcase
            phase_len = $urandom_range(40, 110);
            // now and then an illegal geometry
            if ($urandom_range(0, 11) == 0)
            begin
                phase_len = 15;
                case ($urandom_range(0, 2))
                    0:       new_size  = 32'd0;
                    1:       new_count = 32'd0;
                    default: new_count = $urandom_range(257, 511);
                endcase
            end
            write_reg(CFG_POOL_BASE,   new_base);
            write_reg(CFG_OBJECT_SIZE, new_size);
            write_reg(CFG_SLOT_COUNT,  new_count);
            if ($urandom_range(0, 3) == 0)
                used_map = used_map;
            tx_gapless = ($urandom_range(0, 3) == 0);
            alloc_pct  = $urandom_range(25, 70);
            span       = 64'(cfg_size) * 64'(cfg_count);

            for (int k = 0; k < phase_len; k++)
            begin
                r  = $urandom_range(0, 99);
                a  = $urandom;
                op = OP_FREE;
                if (r < alloc_pct)
                    op = OP_ALLOC;
                else if (cfg_size == 0 || cfg_count == 0 || cfg_count > SLOTS)
                    op = opcode_t'($urandom_range(0, 3));
                else if (r < alloc_pct + 20)
                begin
                    // release a slot that is in use, when there is one
                    start = $urandom_range(0, cfg_count - 1);
                    pick  = start;
                    for (int m = SLOTS - 1; m >= 0; m--)
                    begin
                        if (m < cfg_count)
                        begin
                            j = (start + m) % cfg_count;
                            if (used_map[j])
                                pick = j;
                        end
                    end
                    a = cfg_base + addr_t'(pick) * addr_t'(cfg_size);
                end
                else if (r < 85)
                    a = cfg_base + addr_t'($urandom_range(0, 32'(span) + cfg_size));
                else if (r < 88)
                    a = cfg_base - addr_t'($urandom_range(1, 16));
                else if (r < 92)
                    op = OP_CLEAR;
                else if (r < 95)
                    op = OP_NONE;
                send_item(op, a, 1'b0, none);
            end
        end

        settle();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
